// ===== hw/rtl/kocl_pkg.sv =====
// Shared types, codes and defaults for the K-of-N event confirmation latch.
`default_nettype none

package kocl_pkg;

    // Field widths
    localparam int SCORE_W  = 16;
    localparam int VOTE_W   = 6;
    localparam int MS_W     = 16;
    localparam int PHASE_W  = 17;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 16;

    // Default vote window length
    localparam int VOTE_WINDOW_DEF = 5;

    // Item kinds
    localparam logic [MODE_W-1:0] MODE_FRAME      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK       = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INVALIDATE = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOTES_NEEDED    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LATCH_LENGTH    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF      = 8'd3;

    // Register reset values
    localparam logic signed [SCORE_W-1:0] THRESHOLD_RST = 16'sd128;
    localparam logic [VOTE_W-1:0]         VOTES_RST     = 6'd3;
    localparam logic [MS_W-1:0]           LATCH_RST     = 16'd5000;
    localparam logic [MS_W-1:0]           BLINK_RST     = 16'd250;

    // Push control into the vote ring; the clear travels on its own port
    typedef struct packed {
        logic push;
        logic flag;
    } vote_ctrl_t;

    // Status out of the vote ring, as it stands after this item's push
    typedef struct packed {
        logic [VOTE_W-1:0] count_next;
        logic              full_next;
    } vote_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kocl_vote_ring.sv =====
// Vote ring with running count, write position and saturating fill count.
`default_nettype none

module kocl_vote_ring #(
    parameter int VOTE_WINDOW = kocl_pkg::VOTE_WINDOW_DEF
) (
    input  wire                logic aclk,
    input  wire                logic aresetn,
    input  wire                logic clear,
    input  wire kocl_pkg::vote_ctrl_t ctrl,
    output kocl_pkg::vote_stat_t    stat
);

    localparam int PW = (VOTE_WINDOW > 1) ? $clog2(VOTE_WINDOW) : 1;
    localparam int CW = $clog2(VOTE_WINDOW + 1);
    localparam logic [PW-1:0] POS_LAST = PW'(VOTE_WINDOW - 1);
    localparam logic [CW-1:0] SEEN_MAX = CW'(VOTE_WINDOW);

    logic [VOTE_WINDOW-1:0] ring_reg, ring_next;
    logic [PW-1:0]          pos_reg, pos_next;
    logic [CW-1:0]          seen_reg, seen_next;
    logic [CW-1:0]          count_reg, count_next;

    // Swap the oldest vote for the new one and advance the position
    always_comb begin
        ring_next  = ring_reg;
        pos_next   = pos_reg;
        seen_next  = seen_reg;
        count_next = count_reg;
        if (ctrl.push) begin
            count_next    = count_reg - CW'(ring_reg[pos_reg]) + CW'(ctrl.flag);
            ring_next[pos_reg] = ctrl.flag;
            pos_next      = (pos_reg == POS_LAST) ? '0 : pos_reg + PW'(1);
            if (seen_reg != SEEN_MAX) begin
                seen_next = seen_reg + CW'(1);
            end
        end
    end

    assign stat.count_next = kocl_pkg::VOTE_W'(count_next);
    assign stat.full_next  = (seen_next == SEEN_MAX);

    // Hold the ring; a clear wins over the push
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            ring_reg  <= '0;
            pos_reg   <= '0;
            seen_reg  <= '0;
            count_reg <= '0;
        end else begin
            ring_reg  <= ring_next;
            pos_reg   <= pos_next;
            seen_reg  <= seen_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/k_of_n_event_confirm_latch_core.sv =====
// Top level: frame voting, K-of-N confirmation, alarm latch and LED blink.
// The result of an accepted item is registered in the result register or, if that waits, in the skid entry.
// Throughput: one item per cycle while s_tready is high; all state updates in the accept cycle.
// A two-entry output stage (result register plus skid) lets items be taken
// while a finished result waits; s_tready drops only when both are full.
// Reset (aresetn low, synchronous) clears votes, latch, blink phase and
// output valids, and loads the register defaults.
`default_nettype none

module k_of_n_event_confirm_latch_core #(
    parameter int VOTE_WINDOW = kocl_pkg::VOTE_WINDOW_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write channel
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    // input items
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [15:0] s_tdata,  // [15:0] event_score
    input  wire logic [2:0]  s_tuser,  // [1:0] mode, [2] window_full
    // result items
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [15:0] m_tdata   // [0] frame_flag, [6:1] vote_total,
                                       // [7] confirmed, [8] alarm_active,
                                       // [9] led_on, [15:10] zero
);

    localparam int RES_W = 10;

    // Configuration registers
    logic signed [kocl_pkg::SCORE_W-1:0] threshold_reg;
    logic [kocl_pkg::VOTE_W-1:0]         votes_needed_reg;
    logic [kocl_pkg::MS_W-1:0]           latch_len_reg;
    logic [kocl_pkg::MS_W-1:0]           blink_half_reg;

    // Latch state
    logic [kocl_pkg::MS_W-1:0]    latch_rem_reg, latch_rem_next;
    logic [kocl_pkg::PHASE_W-1:0] phase_reg, phase_next;

    // Output stage
    logic             main_valid_reg, skid_valid_reg;
    logic [RES_W-1:0] main_data_reg, skid_data_reg;

    logic                          accept, pop;
    logic [kocl_pkg::MODE_W-1:0]   mode;
    logic                          win_ready;
    logic signed [kocl_pkg::SCORE_W-1:0] score;
    logic                          is_frame, is_tick, is_inval;
    logic                          flag, confirm, ring_clear;
    logic [kocl_pkg::PHASE_W:0]    full_period, phase_inc;
    logic                          active_next, led_next;
    logic [kocl_pkg::VOTE_W-1:0]   votes_out;
    logic [RES_W-1:0]              result;
    kocl_pkg::vote_ctrl_t          vctrl;
    kocl_pkg::vote_stat_t          vstat;

    assign cfg_ready = 1'b1;

    // Take register writes; ignore indexes beyond the list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg    <= kocl_pkg::THRESHOLD_RST;
            votes_needed_reg <= kocl_pkg::VOTES_RST;
            latch_len_reg    <= kocl_pkg::LATCH_RST;
            blink_half_reg   <= kocl_pkg::BLINK_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                kocl_pkg::REG_SCORE_THRESHOLD: threshold_reg <= cfg_data;
                kocl_pkg::REG_VOTES_NEEDED:
                    votes_needed_reg <= cfg_data[kocl_pkg::VOTE_W-1:0];
                kocl_pkg::REG_LATCH_LENGTH: latch_len_reg <= cfg_data;
                kocl_pkg::REG_BLINK_HALF:   blink_half_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack the item and decode its kind
    assign accept    = s_tvalid && s_tready;
    assign pop       = main_valid_reg && m_tready;
    assign mode      = s_tuser[1:0];
    assign win_ready = s_tuser[2];
    assign score     = s_tdata;

    always_comb begin
        is_frame = 1'b0;
        is_tick  = 1'b0;
        is_inval = 1'b0;
        unique case (mode)
            kocl_pkg::MODE_FRAME:      is_frame = 1'b1;
            kocl_pkg::MODE_TICK:       is_tick  = 1'b1;
            kocl_pkg::MODE_INVALIDATE: is_inval = 1'b1;
            default: ;
        endcase
    end

    // Vote and confirm
    assign flag = accept && is_frame && win_ready && (score >= threshold_reg);

    assign vctrl.push  = accept && is_frame && win_ready;
    assign vctrl.flag  = flag;
    assign ring_clear  = confirm || (accept && is_inval);

    assign confirm = vctrl.push && vstat.full_next &&
                     (vstat.count_next >= votes_needed_reg);

    kocl_vote_ring #(
        .VOTE_WINDOW(VOTE_WINDOW)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (ring_clear),
        .ctrl    (vctrl),
        .stat    (vstat)
    );

    // Count the latch down on ticks and run the blink phase
    assign full_period = {1'b0, blink_half_reg, 1'b0};
    assign phase_inc   = {1'b0, phase_reg} + 18'd1;

    always_comb begin
        latch_rem_next = latch_rem_reg;
        phase_next     = phase_reg;
        if (confirm) begin
            latch_rem_next = latch_len_reg;
            phase_next     = '0;
        end else if (accept && is_tick && (latch_rem_reg != '0)) begin
            latch_rem_next = latch_rem_reg - kocl_pkg::MS_W'(1);
            phase_next     = (phase_inc >= full_period) ? '0
                                                        : phase_inc[kocl_pkg::PHASE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latch_rem_reg <= '0;
            phase_reg     <= '0;
        end else begin
            latch_rem_reg <= latch_rem_next;
            phase_reg     <= phase_next;
        end
    end

    // Build the result from the state after this item; a clear empties the ring
    assign active_next = (latch_rem_next != '0);
    assign led_next    = active_next &&
                         (phase_next < {1'b0, blink_half_reg});
    assign votes_out   = ring_clear ? '0 : vstat.count_next;
    assign result = {led_next, active_next, confirm, votes_out, flag};

    // Output register with skid entry; order kept main first
    assign s_tready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (accept) begin
            if (main_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end else begin
                main_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_data_reg <= skid_data_reg;
            end
        end else if (accept) begin
            if (main_valid_reg && !pop) begin
                skid_data_reg <= result;
            end else begin
                main_data_reg <= result;
            end
        end
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = {6'd0, main_data_reg};

    // Skid entry is only ever used behind a full result register
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry valid with empty result register");

    // A confirmation leaves the ring empty
    a_confirm_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[7]) |-> (m_tdata[6:1] == 6'd0))
        else $error("confirmed result with nonzero vote total");

    // LED lights only while the alarm runs
    a_led_in_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[9]) |-> m_tdata[8])
        else $error("LED on without active alarm");

    // A confirm restarts the latch with the programmed length
    a_latch_load: assert property (@(posedge aclk) disable iff (!aresetn)
        confirm |=> (latch_rem_reg == $past(latch_len_reg)) && (phase_reg == '0))
        else $error("latch not reloaded on confirmation");

endmodule

`default_nettype wire

// ===== test/tb_k_of_n_event_confirm_latch_core.sv =====
// Self-checking testbench for the K-of-N event confirmation latch core.
`timescale 1ns / 1ps

module tb_k_of_n_event_confirm_latch_core;

    localparam int VW  = kocl_pkg::VOTE_WINDOW_DEF;
    localparam int MW  = kocl_pkg::MODE_W;
    localparam int SW  = kocl_pkg::SCORE_W;
    localparam int VTW = kocl_pkg::VOTE_W;
    localparam int IW  = kocl_pkg::CFG_IDX_W;
    localparam int DW  = kocl_pkg::CFG_DATA_W;
    localparam logic [MW-1:0] MODE_SPARE      = 2'd3;
    localparam logic [IW-1:0] BAD_INDEX_FIRST = kocl_pkg::REG_BLINK_HALF + 8'd1;
    localparam logic [IW-1:0] BAD_INDEX_LAST  = 8'hFF;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 93;

    // Receiver stall patterns
    localparam int STALL_READY  = 0;
    localparam int STALL_RANDOM = 1;
    localparam int STALL_SPARSE = 2;

    // One input item as queued for the driver
    typedef struct {
        logic [MW-1:0] mode;
        logic          rdy;
        logic [SW-1:0] score;
    } stim_t;

    // One result item, laid out as m_tdata from the top bit down
    typedef struct packed {
        logic [5:0]     pad;
        logic           led;
        logic           active;
        logic           confirmed;
        logic [VTW-1:0] votes;
        logic           flag;
    } status_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;  // [15:0] event_score
    logic [2:0]  s_tuser   = '0;  // [1:0] mode, [2] window_full
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;         // [0] frame_flag, [6:1] vote_total, [7] confirmed,
                                  // [8] alarm_active, [9] led_on, [15:10] zero

    k_of_n_event_confirm_latch_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Predictor copy of the registers and the block state
    logic signed [SW-1:0] cur_thresh;
    int unsigned cur_needed;
    int unsigned cur_latch;
    int unsigned cur_blink;
    bit          vote_bits [VW];
    int          ring_pos;
    int          frames_in;
    int          held_votes;
    int unsigned latch_left;
    int unsigned blink_pos;

    stim_t   pending_items [$];
    status_t expected_status [$];

    int errors        = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int confirms_seen = 0;
    int reg_writes    = 0;
    bit s_took        = 1'b0;
    int burst_left    = 0;
    int gap_left      = 0;
    int stall_kind    = 0;
    int stall_left    = 0;
    int cycle_no      = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Empty the vote ring and its counters
    task automatic wipe_votes();
        for (int i = 0; i < VW; i++) vote_bits[i] = 1'b0;
        ring_pos   = 0;
        frames_in  = 0;
        held_votes = 0;
    endtask

    // Advance the predicted state by one accepted item and queue its status
    task automatic predict_status(input logic [MW-1:0] md, input logic rdy,
                                  input logic signed [SW-1:0] sc);
        status_t     r;
        int unsigned full;
        r    = '0;
        full = 2 * cur_blink;
        if (md == kocl_pkg::MODE_FRAME) begin
            if (rdy) begin
                r.flag = (sc >= cur_thresh);
                held_votes = held_votes - int'(vote_bits[ring_pos]) + int'(r.flag);
                vote_bits[ring_pos] = r.flag;
                ring_pos = (ring_pos + 1 >= VW) ? 0 : ring_pos + 1;
                if (frames_in < VW) frames_in++;
                if (held_votes >= int'(cur_needed) && frames_in >= VW) begin
                    r.confirmed = 1'b1;
                    wipe_votes();
                    latch_left = cur_latch;
                    blink_pos  = 0;
                end
            end
        end else if (md == kocl_pkg::MODE_TICK) begin
            if (latch_left != 0) begin
                latch_left--;
                if (blink_pos + 1 >= full) blink_pos = 0;
                else blink_pos++;
            end
        end else if (md == kocl_pkg::MODE_INVALIDATE) begin
            wipe_votes();
        end
        r.votes  = held_votes[VTW-1:0];
        r.active = (latch_left != 0);
        r.led    = r.active && (blink_pos < cur_blink);
        expected_status.push_back(r);
    endtask

    // Write one register over the configuration channel
    task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            kocl_pkg::REG_SCORE_THRESHOLD: cur_thresh = val;
            kocl_pkg::REG_VOTES_NEEDED:    cur_needed = 32'(val[VTW-1:0]);
            kocl_pkg::REG_LATCH_LENGTH:    cur_latch  = 32'(val);
            kocl_pkg::REG_BLINK_HALF:      cur_blink  = 32'(val);
            default: ;
        endcase
        reg_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic add_item(input logic [MW-1:0] md, input logic rdy,
                            input logic [SW-1:0] sc);
        stim_t it;
        it.mode  = md;
        it.rdy   = rdy;
        it.score = sc;
        pending_items.push_back(it);
    endtask

    // Wait until every queued item is taken and every result has come back
    task automatic settle();
        int guard;
        guard = 0;
        while ((pending_items.size() != 0 || s_tvalid || expected_status.size() != 0)
               && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        if (expected_status.size() != 0 || pending_items.size() != 0) begin
            errors++;
            if (errors <= 10)
                $display("ERROR: %0d results still expected, %0d items unsent",
                         expected_status.size(), pending_items.size());
        end
        repeat (4) @(posedge aclk);
    endtask

    // Score mostly close to the threshold so that votes are mixed
    function automatic logic [SW-1:0] pick_score();
        int roll;
        int s;
        roll = $urandom_range(0, 99);
        if (roll < 25) return 16'($urandom);
        if (roll < 30) return 16'h8000;
        if (roll < 35) return 16'h7FFF;
        s = int'(cur_thresh) + int'($urandom_range(0, 6)) - 3;
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        return s[SW-1:0];
    endfunction

    // Sender: present queued items in bursts with gaps between them
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_took) begin
            // hold the item until it is taken
        end else if (gap_left != 0) begin
            gap_left--;
            s_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
            s_tvalid <= 1'b1;
            s_tdata  <= pending_items[0].score;
            s_tuser  <= {pending_items[0].rdy, pending_items[0].mode};
            if (burst_left == 0) burst_left = $urandom_range(1, 24);
            burst_left--;
            if (burst_left == 0)
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Receiver: stall on segments of always-ready, random and mostly-stalled
    always @(negedge aclk) begin
        cycle_no++;
        if (stall_left == 0) begin
            stall_kind = $urandom_range(STALL_READY, STALL_SPARSE);
            stall_left = $urandom_range(10, 60);
        end
        stall_left--;
        case (stall_kind)
            STALL_READY:  m_tready <= 1'b1;
            STALL_RANDOM: m_tready <= 1'($urandom_range(0, 1));
            default:      m_tready <= (cycle_no % 7 < 2);
        endcase
    end

    // Take accepted input items into the predictor and check result items
    always @(posedge aclk) begin
        status_t got;
        status_t want;
        s_took = aresetn && s_tvalid && s_tready;
        if (s_took) begin
            predict_status(s_tuser[1:0], s_tuser[2], s_tdata);
            void'(pending_items.pop_front());
            items_sent++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            results_seen++;
            if (got.confirmed) confirms_seen++;
            if (expected_status.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: unexpected result %h", m_tdata);
            end else begin
                want = expected_status.pop_front();
                if (got.flag !== want.flag || got.votes !== want.votes ||
                    got.confirmed !== want.confirmed || got.active !== want.active ||
                    got.led !== want.led || got.pad !== want.pad) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("ERROR: result %0d flag/votes/conf/act/led/pad %0b/%0d/%0b/%0b/%0b/%h",
                                 results_seen, got.flag, got.votes, got.confirmed,
                                 got.active, got.led, got.pad);
                        $display("       expected %0b/%0d/%0b/%0b/%0b/%h",
                                 want.flag, want.votes, want.confirmed,
                                 want.active, want.led, want.pad);
                    end
                end
            end
        end
    end

    // Main sequence: reset, directed cases, then random phases
    initial begin
        logic [SW-1:0] thr;
        logic [DW-1:0] need;
        logic [DW-1:0] lat;
        logic [DW-1:0] blk;
        int useful;
        int roll;
        cur_thresh = kocl_pkg::THRESHOLD_RST;
        cur_needed = 32'(kocl_pkg::VOTES_RST);
        cur_latch  = 32'(kocl_pkg::LATCH_RST);
        cur_blink  = 32'(kocl_pkg::BLINK_RST);
        wipe_votes();
        latch_left = 0;
        blink_pos  = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: small alarm so every phase of the blink is reached
        write_reg(kocl_pkg::REG_SCORE_THRESHOLD, 16'd0);
        write_reg(kocl_pkg::REG_VOTES_NEEDED, 16'd2);
        write_reg(kocl_pkg::REG_LATCH_LENGTH, 16'd6);
        write_reg(kocl_pkg::REG_BLINK_HALF, 16'd2);
        add_item(kocl_pkg::MODE_FRAME, 1'b0, 16'h7FFF);  // window not ready: dropped
        add_item(kocl_pkg::MODE_TICK, 1'b0, 16'h0000);   // tick with the alarm idle
        add_item(MODE_SPARE, 1'b1, 16'hFFFF);            // unused mode
        add_item(kocl_pkg::MODE_FRAME, 1'b1, 16'h8000);
        add_item(kocl_pkg::MODE_FRAME, 1'b1, 16'h0000);  // score equal to threshold
        add_item(kocl_pkg::MODE_FRAME, 1'b1, 16'hFFFF);
        add_item(kocl_pkg::MODE_FRAME, 1'b1, 16'h7FFF);
        add_item(kocl_pkg::MODE_INVALIDATE, 1'b1, 16'h7FFF);
        repeat (5) add_item(kocl_pkg::MODE_FRAME, 1'b1, 16'h0001);
        repeat (3) add_item(kocl_pkg::MODE_TICK, 1'b1, 16'h5555);
        settle();

        // Shrink the half period below the running phase, then tick out the alarm
        write_reg(kocl_pkg::REG_BLINK_HALF, 16'd1);
        repeat (3) add_item(kocl_pkg::MODE_TICK, 1'b0, 16'hAAAA);
        settle();

        // Zero votes needed with zero latch length: confirm without an alarm
        write_reg(kocl_pkg::REG_VOTES_NEEDED, 16'd0);
        write_reg(kocl_pkg::REG_LATCH_LENGTH, 16'd0);
        write_reg(BAD_INDEX_LAST, 16'hFFFF);
        repeat (5) add_item(kocl_pkg::MODE_FRAME, 1'b1, 16'hFFFF);
        add_item(kocl_pkg::MODE_TICK, 1'b0, 16'h0000);
        settle();

        // Random phases, each under its own register setting
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            thr  = ($urandom_range(0, 1) != 0) ? 16'($urandom)
                                               : 16'(int'($urandom_range(0, 512)) - 256);
            need = 16'($urandom_range(1, 6));
            lat  = 16'($urandom_range(1, 40));
            blk  = 16'($urandom_range(1, 8));
            case (ph)
                0: thr = 16'h8000;
                1: thr = 16'h7FFF;
                2: need = 16'd0;
                3: need = 16'd63;
                4: need = 16'd32;
                5: lat = 16'hFFFF;
                6: lat = 16'd0;
                7: blk = 16'hFFFF;
                8: blk = 16'd0;
                9: blk = 16'd1;
                default: ;
            endcase
            write_reg(kocl_pkg::REG_SCORE_THRESHOLD, thr);
            write_reg(kocl_pkg::REG_VOTES_NEEDED, need);
            write_reg(kocl_pkg::REG_LATCH_LENGTH, lat);
            write_reg(kocl_pkg::REG_BLINK_HALF, blk);
            if (ph % 3 == 0) write_reg(BAD_INDEX_FIRST + 8'(ph), 16'($urandom));
            useful = 0;
            while (useful < PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                if (roll < 55) begin
                    add_item(kocl_pkg::MODE_FRAME, 1'b1, pick_score());
                    useful++;
                end else if (roll < 80) begin
                    add_item(kocl_pkg::MODE_TICK, 1'($urandom_range(0, 1)), 16'($urandom));
                    useful++;
                end else if (roll < 86) begin
                    add_item(kocl_pkg::MODE_INVALIDATE, 1'($urandom_range(0, 1)),
                             16'($urandom));
                    useful++;
                end else if (roll < 93) begin
                    add_item(kocl_pkg::MODE_FRAME, 1'b0, 16'($urandom));
                end else begin
                    add_item(MODE_SPARE, 1'($urandom_range(0, 1)), 16'($urandom));
                end
            end
            settle();
        end

        $display("Run covered %0d items, %0d results checked, %0d confirmations,",
                 items_sent, results_seen, confirms_seen);
        $display("%0d register writes over %0d random settings; %0d mismatches",
                 reg_writes, RANDOM_PHASES, errors);
        if (errors == 0) begin
            $display("k_of_n_event_confirm_latch_core regression: pass");
        end else begin
            $display("k_of_n_event_confirm_latch_core regression: fail");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #400000;
        $display("ERROR: timeout with %0d results outstanding", expected_status.size());
        $display("k_of_n_event_confirm_latch_core regression: fail");
        $finish;
    end

endmodule
